[hw/rtl/kbs_pkg.sv]
// Package: sizes, operation codes and word types of the ones-count select tree.
package kbs_pkg;

  localparam int ENTRIES = 1024;               // power of two, perfect tree
  localparam int LEVELS  = $clog2(ENTRIES);    // leaf level
  localparam int NODES   = 2 * ENTRIES - 1;
  localparam int POS_W   = 10;
  localparam int CNT_W   = 11;
  localparam int ADDR_W  = $clog2(NODES);
  localparam int LVL_W   = (LEVELS > 1) ? $clog2(LEVELS) : 1;

  localparam logic [1:0] OP_SET    = 2'd0;
  localparam logic [1:0] OP_TOGGLE = 2'd1;
  localparam logic [1:0] OP_SELECT = 2'd2;

  typedef struct packed {
    logic [1:0]       operation;
    logic [POS_W-1:0] bit_position;
    logic             bit_value;
    logic [POS_W-1:0] rank;
  } kbs_in_t;

  typedef struct packed {
    logic [POS_W-1:0] found_position;
    logic             not_found;
    logic [CNT_W-1:0] ones_total;
  } kbs_out_t;

endpackage

[hw/rtl/kth_set_bit_select_tree_top.sv]
// Ones-count tree over a bit vector with set, toggle and ranked select.
//
// Input channel in_valid/in_ready/in_data carries one operation word: set a
// bit, toggle a bit, or select the position of the one of a given rank.
// Output channel out_valid/out_ready/out_data returns one word per input
// word: found position, not_found flag and the ones count after the word.
// The node counts sit in one memory (heap order, root at address 0); a
// single read port and a single write port are walked one tree level per
// cycle by the sequencer.
// A set/toggle reads the leaf and, when the bit changes, does one
// read-modify-write per ancestor level up to level one; a select does one
// compare per level; a miss, an unchanged bit or the unused operation code
// goes straight to the output. in_ready is high only in idle, entered as
// out_valid rises, so a word is taken only once the last result is in the
// output register. After reset the memory is cleared by a pass over all
// 2*ENTRIES-1 nodes (2047) with in_ready low. A stalled receiver holds the
// result in the output register; the next input word is still accepted and
// worked on, and its result waits until the output register frees up.
module kth_set_bit_select_tree_top
  import kbs_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  kbs_in_t in_data,
  output logic    out_valid,
  input  logic    out_ready,
  output kbs_out_t out_data
);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_START, S_LEAF, S_UP, S_SEL, S_OUT
  } state_t;

  state_t           state;
  kbs_in_t          cur;
  logic [ADDR_W-1:0] clr_addr;
  logic [ADDR_W-1:0] base;     // address of first node of the level in hand
  logic [POS_W-1:0]  idx;      // node index within that level
  logic [LVL_W-1:0]  lvl;
  logic [POS_W-1:0]  rem;
  logic [CNT_W-1:0]  total;
  logic              inc;
  logic [POS_W-1:0]  found;
  logic              miss;

  // node count memory
  logic [CNT_W-1:0]  mem [NODES];
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [CNT_W-1:0]  mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  logic [CNT_W-1:0]  mem_rdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= mem[mem_raddr];
  end

  logic              pos_ok;
  logic              is_upd;
  logic              old_bit;
  logic              new_bit;
  logic              go_left;
  logic [POS_W-1:0]  sel_idx;
  logic [ADDR_W-1:0] sel_base;
  logic [ADDR_W-1:0] up_base;
  logic [POS_W-1:0]  up_idx;

  assign pos_ok   = (CNT_W'(cur.bit_position) < CNT_W'(ENTRIES));
  assign is_upd   = (cur.operation == OP_SET) || (cur.operation == OP_TOGGLE);
  assign old_bit  = mem_rdata[0];
  assign new_bit  = (cur.operation == OP_TOGGLE) ? ~old_bit : cur.bit_value;
  assign go_left  = (CNT_W'(rem) < mem_rdata);
  assign sel_idx  = {idx[POS_W-2:0], ~go_left};
  assign sel_base = {base[ADDR_W-2:0], 1'b1};
  assign up_base  = base >> 1;
  assign up_idx   = idx >> 1;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_raddr = '0;
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
      end
      S_START: begin
        if (cur.operation == OP_SELECT) begin
          mem_raddr = ADDR_W'(1);   // left child of the root
        end else begin
          mem_raddr = ADDR_W'(ENTRIES - 1) + ADDR_W'(cur.bit_position);
        end
      end
      S_LEAF: begin
        mem_we    = 1'b1;
        mem_waddr = base + ADDR_W'(idx);
        mem_wdata = CNT_W'(new_bit);
        mem_raddr = up_base + ADDR_W'(up_idx);
      end
      S_UP: begin
        mem_we    = 1'b1;
        mem_waddr = base + ADDR_W'(idx);
        mem_wdata = inc ? mem_rdata + CNT_W'(1) : mem_rdata - CNT_W'(1);
        mem_raddr = up_base + ADDR_W'(up_idx);
      end
      S_SEL: begin
        mem_raddr = sel_base + ADDR_W'({sel_idx[POS_W-2:0], 1'b0});
      end
      default: begin
      end
    endcase
  end

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      total     <= '0;
      out_valid <= 1'b0;
    end else begin
      // S_OUT handles the drain itself when it loads the next word
      if (out_valid && out_ready && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == ADDR_W'(NODES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            cur   <= in_data;
            state <= S_START;
          end
        end
        S_START: begin
          found <= '0;
          if (is_upd && pos_ok) begin
            miss  <= 1'b0;
            base  <= ADDR_W'(ENTRIES - 1);
            idx   <= cur.bit_position;
            state <= S_LEAF;
          end else if ((cur.operation == OP_SELECT) && (CNT_W'(cur.rank) < total)) begin
            miss  <= 1'b0;
            base  <= ADDR_W'(1);
            idx   <= '0;
            lvl   <= '0;
            rem   <= cur.rank;
            state <= S_SEL;
          end else begin
            miss  <= (cur.operation == OP_SELECT);
            state <= S_OUT;
          end
        end
        S_LEAF: begin
          base <= up_base;
          idx  <= up_idx;
          inc  <= new_bit;
          if (new_bit != old_bit) begin
            total <= new_bit ? total + CNT_W'(1) : total - CNT_W'(1);
          end
          // root count lives in total, so the walk stops at level one
          if ((new_bit == old_bit) || (base == ADDR_W'(1))) begin
            state <= S_OUT;
          end else begin
            state <= S_UP;
          end
        end
        S_UP: begin
          base <= up_base;
          idx  <= up_idx;
          if (base == ADDR_W'(1)) begin
            state <= S_OUT;
          end
        end
        S_SEL: begin
          if (!go_left) begin
            rem <= rem - mem_rdata[POS_W-1:0];
          end
          idx  <= sel_idx;
          base <= sel_base;
          lvl  <= lvl + LVL_W'(1);
          if (lvl == LVL_W'(LEVELS - 1)) begin
            found <= sel_idx;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_data.found_position <= found;
            out_data.not_found      <= miss;
            out_data.ones_total     <= total;
            out_valid               <= 1'b1;
            state                   <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
